### hdl/btr_pkg.sv
// Shared types and constants for the bitmap text row renderer.
// No dependencies; imported by every module of the block.
package btr_pkg;

    localparam int SCREEN_WIDTH     = 128;
    localparam int SCREEN_HEIGHT    = 160;
    localparam int FONT_DEPTH       = 4096;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int RESULT_CAP       = 32;
    localparam int HEIGHT_CAP       = (MAX_GLYPH_HEIGHT > RESULT_CAP) ? RESULT_CAP :
                                      (MAX_GLYPH_HEIGHT < 1) ? 1 : MAX_GLYPH_HEIGHT;
    localparam int FONT_AW          = $clog2(FONT_DEPTH);

    localparam logic [7:0]  FIRST_CODE = 8'd32;
    localparam logic [7:0]  LAST_CODE  = 8'd127;
    localparam logic [15:0] TOP_BIT    = 16'h8000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        CFG_GLYPH_WIDTH  = 1'b0,
        CFG_GLYPH_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        CMD_FONT_WRITE = 1'b0,
        CMD_DRAW       = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ROW     = 2'd0,
        ST_BAD_CHR = 2'd1,
        ST_BOUNDS  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        JOB_WRITE = 2'd0,
        JOB_ERROR = 2'd1,
        JOB_GLYPH = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic        cmd;
        logic [11:0] font_addr;
        logic [15:0] font_word;
        logic [7:0]  char_code;
        logic        first_char;
        logic [7:0]  start_x;
        logic [7:0]  start_y;
    } btr_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [15:0] row_mask;
        logic        last_row;
    } btr_out_t;

    // One queued job: font write, error beat, or a glyph of row reads.
    typedef struct packed {
        job_kind_t          kind;
        status_t            status;
        logic [7:0]         x;
        logic [7:0]         y;
        logic [FONT_AW-1:0] addr;   // write address or glyph base
        logic [15:0]        data;   // font word or width mask
        logic [5:0]         rows;   // glyph height, 1..HEIGHT_CAP
    } btr_job_t;

endpackage

### hdl/btr_queue.sv
// Short job queue between front and back of the text renderer.
// Depends on btr_pkg for the job type and depth.
module btr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  btr_pkg::btr_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output btr_pkg::btr_job_t head_job
);
    import btr_pkg::*;

    btr_job_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg,  count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hdl/btr_front.sv
// Front end: config registers, text cursor, and per-character classification.
// Depends on btr_pkg; emits one job per font write or per character with output.
module btr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_index,
    input  logic [5:0]        cfg_data,
    input  logic              in_accept,
    input  btr_pkg::btr_in_t  in_item,
    output logic              push,
    output btr_pkg::btr_job_t push_job
);
    import btr_pkg::*;

    logic [4:0] gw_reg;
    logic [5:0] gh_reg;
    logic [7:0] col_reg,  col_next;
    logic [7:0] row_reg,  row_next;
    logic       done_reg, done_next;

    logic [4:0] w;
    logic [5:0] h;
    logic [7:0] col0, row0, col1, row1, row_wrapped;
    logic       done0, wrap, bottom, bad_chr, oob;
    logic [8:0] col_end0, col_end1, row_end1;
    logic [6:0] code_off;
    logic [15:0] mask;

    always_comb
    begin
        if (gw_reg == '0)
            w = 5'd1;
        else if (gw_reg > 5'd16)
            w = 5'd16;
        else
            w = gw_reg;
        if (gh_reg == '0)
            h = 6'd1;
        else if (gh_reg > 6'(HEIGHT_CAP))
            h = 6'(HEIGHT_CAP);
        else
            h = gh_reg;
    end

    always_comb
    begin
        col0        = in_item.first_char ? in_item.start_x : col_reg;
        row0        = in_item.first_char ? in_item.start_y : row_reg;
        done0       = in_item.first_char ? 1'b0 : done_reg;
        col_end0    = {1'b0, col0} + {4'b0, w};
        wrap        = (col_end0 > 9'(SCREEN_WIDTH));
        row_wrapped = row0 + {2'b0, h};
        col1        = wrap ? 8'd0 : col0;
        row1        = wrap ? row_wrapped : row0;
        col_end1    = {1'b0, col1} + {4'b0, w};
        row_end1    = {1'b0, row1} + {3'b0, h};
        bottom      = wrap && (row_end1 > 9'(SCREEN_HEIGHT));
        bad_chr     = (in_item.char_code < FIRST_CODE) || (in_item.char_code > LAST_CODE);
        oob         = ({1'b0, col1} >= 9'(SCREEN_WIDTH))
                   || ({1'b0, row1} >= 9'(SCREEN_HEIGHT))
                   || (col_end1 > 9'(SCREEN_WIDTH))
                   || (row_end1 > 9'(SCREEN_HEIGHT));
        code_off    = 7'(in_item.char_code - FIRST_CODE);
        mask        = 16'(16'hFFFF << (5'd16 - w));
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        done_next = done_reg;
        push      = 1'b0;
        push_job  = '{kind: JOB_WRITE, status: ST_ROW, x: col1, y: row1,
                      addr: in_item.font_addr[FONT_AW-1:0],
                      data: in_item.font_word, rows: h};
        if (in_accept)
        begin
            if (in_item.cmd == CMD_FONT_WRITE)
            begin
                push = 1'b1;
            end
            else if (!done0)
            begin
                col_next  = col1;
                row_next  = row1;
                done_next = 1'b0;
                if (bottom)
                begin
                    done_next = 1'b1;
                end
                else if (bad_chr)
                begin
                    done_next       = 1'b1;
                    push            = 1'b1;
                    push_job.kind   = JOB_ERROR;
                    push_job.status = ST_BAD_CHR;
                end
                else if (oob)
                begin
                    done_next       = 1'b1;
                    push            = 1'b1;
                    push_job.kind   = JOB_ERROR;
                    push_job.status = ST_BOUNDS;
                end
                else
                begin
                    col_next      = col_end1[7:0];
                    push          = 1'b1;
                    push_job.kind = JOB_GLYPH;
                    push_job.addr = FONT_AW'(code_off) * FONT_AW'(h);
                    push_job.data = mask;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= 5'd7;
            gh_reg   <= 6'd10;
            col_reg  <= '0;
            row_reg  <= '0;
            done_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_GLYPH_WIDTH)
                gw_reg <= cfg_data[4:0];
            if (cfg_valid && cfg_index == CFG_GLYPH_HEIGHT)
                gh_reg <= cfg_data;
            col_reg  <= col_next;
            row_reg  <= row_next;
            done_reg <= done_next;
        end
    end

endmodule

### hdl/btr_back.sv
// Back end: font store, row read sequencer and output register.
// Depends on btr_pkg; pulls jobs from btr_queue and drives the result beats.
module btr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  btr_pkg::btr_job_t  job,
    output logic               job_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output btr_pkg::btr_out_t  out_data
);
    import btr_pkg::*;

    logic [15:0] font_mem [FONT_DEPTH];

    // current job being sequenced
    logic        cur_valid_reg, cur_valid_next;
    btr_job_t    cur_reg;
    logic [4:0]  idx_reg, idx_next;

    // stage 1: read data in flight
    logic        s1_valid_reg;
    logic        s1_err_reg;
    status_t     s1_status_reg;
    logic [7:0]  s1_x_reg, s1_y_reg;
    logic [15:0] s1_mask_reg;
    logic        s1_last_reg;
    logic [15:0] rd_data_reg;

    logic        out_valid_reg;
    btr_out_t    out_reg;

    logic        adv_out, adv_s1, issue, cur_last, load, load_write;
    logic [FONT_AW-1:0] rd_addr;

    assign adv_out    = !out_valid_reg || out_ready;
    assign adv_s1     = !s1_valid_reg || adv_out;
    assign issue      = cur_valid_reg && adv_s1;
    assign cur_last   = (cur_reg.kind == JOB_ERROR) || ({1'b0, idx_reg} == cur_reg.rows - 1'b1);
    assign load       = job_valid && (!cur_valid_reg || (issue && cur_last));
    assign load_write = load && (job.kind == JOB_WRITE);
    assign job_pop    = load;
    assign rd_addr    = cur_reg.addr + FONT_AW'(idx_reg);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (issue)
        begin
            idx_next = idx_reg + 1'b1;
            if (cur_last)
                cur_valid_next = 1'b0;
        end
        if (load)
        begin
            cur_valid_next = !load_write;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (adv_s1)
                s1_valid_reg <= issue;
            if (adv_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= job;
        if (issue)
        begin
            s1_err_reg    <= (cur_reg.kind == JOB_ERROR);
            s1_status_reg <= cur_reg.status;
            s1_x_reg      <= cur_reg.x;
            s1_y_reg      <= cur_reg.y + {3'b0, idx_reg};
            s1_mask_reg   <= cur_reg.data;
            s1_last_reg   <= cur_last;
        end
        if (adv_out && s1_valid_reg)
        begin
            out_reg.status   <= s1_status_reg;
            out_reg.pixel_x  <= s1_x_reg;
            out_reg.pixel_y  <= s1_y_reg;
            out_reg.row_mask <= s1_err_reg ? 16'h0000 : (rd_data_reg & s1_mask_reg);
            out_reg.last_row <= s1_last_reg;
        end
    end

    // font store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_write)
            font_mem[job.addr] <= job.data;
        if (issue)
            rd_data_reg <= font_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### hdl/bitmap_text_row_renderer.sv
// Top level of the bitmap text row renderer: front, job queue, back.
// Depends on btr_pkg, btr_front, btr_queue and btr_back.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------
//   in      | input     | in_valid/in_ready   | btr_in_t: font write or char
//   out     | output    | out_valid/out_ready | btr_out_t: glyph row or error
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data[5:0]
//
// The front takes one item per cycle while the four-entry job queue has room.
// The back emits one row per cycle while the output is not stalled, a rate set
// by the single read port of the font store; an error gives one beat, a font write none.
// The first result beat passes the queue, the current-job register, the read
// stage and the output register. Output stalls back up through the queue; no
// clearing pass after reset.
module bitmap_text_row_renderer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  btr_pkg::btr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output btr_pkg::btr_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [5:0]        cfg_data
);
    import btr_pkg::*;

    logic     q_full, q_not_empty, q_pop, push;
    btr_job_t push_job, head_job;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;

    btr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_valid && in_ready),
        .in_item   (in_data),
        .push      (push),
        .push_job  (push_job)
    );

    btr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    btr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (head_job),
        .job_pop   (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### hdl/btr_checker.sv
// Port-level checks for the bitmap text row renderer, bound to the top level.
// Depends on btr_pkg for the result type and status codes.
module btr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input btr_pkg::btr_out_t out_data
);
    import btr_pkg::*;

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // error beats are single, maskless
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_ROW |-> out_data.last_row && out_data.row_mask == '0)
        else $error("error beat malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status == ST_ROW || out_data.status == ST_BAD_CHR
                   || out_data.status == ST_BOUNDS)
        else $error("unknown status code");

    // rows of one glyph follow at the same column, one screen row apart
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_row |=>
            !out_valid || (out_data.pixel_x == $past(out_data.pixel_x)
                           && out_data.pixel_y == 8'($past(out_data.pixel_y) + 8'd1)))
        else $error("glyph rows out of sequence");

endmodule

bind bitmap_text_row_renderer btr_checker u_btr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
